// ===== rtl/hcw_pkg.sv =====
`timescale 1ns / 1ps
package hcw_pkg;

  localparam int QW = 20;  // widest quotient (score)
  localparam int OUT_CW = 25;

  localparam logic [2:0] REG_HUE_LOW_A = 3'd0;
  localparam logic [2:0] REG_HUE_HIGH_A = 3'd1;
  localparam logic [2:0] REG_HUE_LOW_B = 3'd2;
  localparam logic [2:0] REG_HUE_HIGH_B = 3'd3;
  localparam logic [2:0] REG_WINDOW_B_ON = 3'd4;
  localparam logic [2:0] REG_SAT_LOW = 3'd5;
  localparam logic [2:0] REG_VAL_LOW = 3'd6;

  localparam logic [7:0] RST_HUE_LOW_A = 8'd0;
  localparam logic [7:0] RST_HUE_HIGH_A = 8'd10;
  localparam logic [7:0] RST_HUE_LOW_B = 8'd170;
  localparam logic [7:0] RST_HUE_HIGH_B = 8'd180;
  localparam logic RST_WINDOW_B_ON = 1'b1;
  localparam logic [7:0] RST_SAT_LOW = 8'd120;
  localparam logic [7:0] RST_VAL_LOW = 8'd70;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SGO, ST_SWAIT, ST_HGO, ST_HWAIT,
    ST_TALLY, ST_QGO, ST_QWAIT, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_SAT, DIV_HUE, DIV_SCORE
  } div_sel_t;

  typedef struct packed {
    logic [7:0] hue_low_a;
    logic [7:0] hue_high_a;
    logic [7:0] hue_low_b;
    logic [7:0] hue_high_b;
    logic window_b_on;
    logic [7:0] sat_low;
    logic [7:0] val_low;
  } cfg_t;

  typedef struct packed {
    logic load_pix;
    logic prep;
    logic div_start;
    div_sel_t div_sel;
    logic latch_s;
    logic latch_h;
    logic tally;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/hcw_divider.sv =====
`timescale 1ns / 1ps
module hcw_divider #(
  parameter int DW = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         num_hi,
  input  logic [hcw_pkg::QW-1:0] num_lo,
  input  logic [DW-1:0]         den,
  input  logic [4:0]            nbits,
  output logic                  busy,
  output logic [hcw_pkg::QW-1:0] quo
);

  logic [DW-1:0] rem;
  logic [hcw_pkg::QW-1:0] low;
  logic [DW-1:0] dvs;
  logic [4:0] cnt;
  logic [DW:0] shifted;
  logic ge;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign shifted = {rem, low[hcw_pkg::QW-1]};
  assign ge = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= nbits;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      low <= num_lo;
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? DW'(shifted - {1'b0, dvs}) : shifted[DW-1:0];
      low <= {low[hcw_pkg::QW-2:0], 1'b0};
      quo <= {quo[hcw_pkg::QW-2:0], ge};
    end
  end

endmodule

// ===== rtl/hcw_datapath.sv =====
`timescale 1ns / 1ps
module hcw_datapath #(
  parameter int MAX_PIXELS = 16777216
) (
  input  logic                clk,
  input  logic                rst,
  input  hcw_pkg::cfg_t       cfg,
  input  hcw_pkg::cmd_t       cmd,
  output hcw_pkg::stat_t      stat,
  input  logic [23:0]         pix_data,
  input  logic                pix_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [71:0]         out_data
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int DW = (CW > 9) ? CW : 9;
  localparam logic [CW-1:0] TALLY_MAX = CW'(MAX_PIXELS);

  logic [7:0] red, green, blue;
  logic last;
  logic [7:0] v_q, diff_q, s_q, h_q;
  logic [16:0] snum_q, hnum_q;
  logic [CW-1:0] match_tally, pixel_tally;
  logic [hcw_pkg::OUT_CW-1:0] out_match, out_pixel;
  logic [hcw_pkg::QW-1:0] out_score;

  logic [7:0] vmax, vmin, diff;
  logic signed [17:0] t_raw, t_adj;
  logic [16:0] snum, hnum;
  logic [CW+3:0] m10;
  logic [DW-1:0] d_hi, d_den;
  logic [hcw_pkg::QW-1:0] d_lo, quo;
  logic [4:0] d_nb;
  logic busy, hit;
  logic [CW+hcw_pkg::OUT_CW-1:0] m_ext, p_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      red <= pix_data[7:0];
      green <= pix_data[15:8];
      blue <= pix_data[23:16];
      last <= pix_last;
    end
  end

  // max, min, diff, the hue numerator in degrees times diff and the saturation numerator
  always_comb begin
    vmax = red;
    vmin = red;
    if (green > vmax) vmax = green;
    if (blue > vmax) vmax = blue;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    diff = vmax - vmin;
    if (vmax == red) begin
      t_raw = (18'($signed({1'b0, green})) - 18'($signed({1'b0, blue}))) * 18'sd60;
    end else if (vmax == green) begin
      t_raw = (18'($signed({1'b0, blue})) - 18'($signed({1'b0, red}))) * 18'sd60
              + 18'($signed({1'b0, diff})) * 18'sd120;
    end else begin
      t_raw = (18'($signed({1'b0, red})) - 18'($signed({1'b0, green}))) * 18'sd60
              + 18'($signed({1'b0, diff})) * 18'sd240;
    end
    t_adj = t_raw[17] ? t_raw + 18'($signed({1'b0, diff})) * 18'sd360 : t_raw;
    hnum = 17'(t_adj) + 17'(diff);
    snum = {diff, 9'b0} - 17'({diff, 1'b0}) + 17'(vmax);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      v_q <= vmax;
      diff_q <= diff;
      snum_q <= snum;
      hnum_q <= hnum;
    end
  end

  assign m10 = {match_tally, 3'b0} + {2'b0, match_tally, 1'b0};

  always_comb begin
    case (cmd.div_sel)
      hcw_pkg::DIV_SAT: begin
        d_hi = DW'(snum_q[16:8]);
        d_lo = {snum_q[7:0], 12'b0};
        d_den = DW'({v_q, 1'b0});
        d_nb = 5'd8;
      end
      hcw_pkg::DIV_HUE: begin
        d_hi = DW'(hnum_q[16:8]);
        d_lo = {hnum_q[7:0], 12'b0};
        d_den = DW'({diff_q, 1'b0});
        d_nb = 5'd8;
      end
      default: begin
        d_hi = DW'(m10[CW+3:4]);
        d_lo = {m10[3:0], 16'b0};
        d_den = DW'(pixel_tally);
        d_nb = 5'd20;
      end
    endcase
  end

  hcw_divider #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num_hi(d_hi), .num_lo(d_lo),
    .den(d_den), .nbits(d_nb), .busy(busy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_s) s_q <= (v_q == 8'd0) ? 8'd0 : quo[7:0];
    if (cmd.latch_h) h_q <= (diff_q == 8'd0) ? 8'd0 : quo[7:0];
  end

  assign hit = (((h_q >= cfg.hue_low_a) && (h_q <= cfg.hue_high_a)) ||
                (cfg.window_b_on && (h_q >= cfg.hue_low_b) && (h_q <= cfg.hue_high_b))) &&
               (s_q >= cfg.sat_low) && (v_q >= cfg.val_low);

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      match_tally <= '0;
      pixel_tally <= '0;
    end else if (cmd.tally) begin
      if (hit && (match_tally < TALLY_MAX)) match_tally <= match_tally + 1'b1;
      if (pixel_tally < TALLY_MAX) pixel_tally <= pixel_tally + 1'b1;
    end
  end

  assign m_ext = {{hcw_pkg::OUT_CW{1'b0}}, match_tally};
  assign p_ext = {{hcw_pkg::OUT_CW{1'b0}}, pixel_tally};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_match <= m_ext[hcw_pkg::OUT_CW-1:0];
      out_pixel <= p_ext[hcw_pkg::OUT_CW-1:0];
      out_score <= quo;
    end
  end

  assign out_data = {2'b0, out_score, out_pixel, out_match};

  assign stat.div_busy = busy;
  assign stat.last = last;
  assign stat.out_free = !out_valid || out_ready;

  a_match_le_pixel: assert property (@(posedge clk) disable iff (rst)
    match_tally <= pixel_tally) else $error("match tally above pixel tally");
  a_tally_sat: assert property (@(posedge clk) disable iff (rst)
    pixel_tally <= TALLY_MAX) else $error("pixel tally passed its limit");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (pixel_tally == '0) && out_valid) else $error("emit did not clear");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !busy) else $error("divider restarted while busy");

endmodule

// ===== rtl/hcw_ctrl.sv =====
`timescale 1ns / 1ps
module hcw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcw_pkg::stat_t stat,
  output hcw_pkg::cmd_t  cmd
);

  hcw_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.div_sel = hcw_pkg::DIV_SAT;
    in_ready = 1'b0;
    case (state)
      hcw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pix = 1'b1;
          state_next = hcw_pkg::ST_PREP;
        end
      end
      hcw_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = hcw_pkg::ST_SGO;
      end
      hcw_pkg::ST_SGO: begin
        cmd.div_start = 1'b1;
        state_next = hcw_pkg::ST_SWAIT;
      end
      hcw_pkg::ST_SWAIT: begin
        if (!stat.div_busy) begin
          cmd.latch_s = 1'b1;
          state_next = hcw_pkg::ST_HGO;
        end
      end
      hcw_pkg::ST_HGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = hcw_pkg::DIV_HUE;
        state_next = hcw_pkg::ST_HWAIT;
      end
      hcw_pkg::ST_HWAIT: begin
        if (!stat.div_busy) begin
          cmd.latch_h = 1'b1;
          state_next = hcw_pkg::ST_TALLY;
        end
      end
      hcw_pkg::ST_TALLY: begin
        cmd.tally = 1'b1;
        state_next = stat.last ? hcw_pkg::ST_QGO : hcw_pkg::ST_IDLE;
      end
      hcw_pkg::ST_QGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = hcw_pkg::DIV_SCORE;
        state_next = hcw_pkg::ST_QWAIT;
      end
      hcw_pkg::ST_QWAIT: begin
        if (!stat.div_busy) state_next = hcw_pkg::ST_EMIT;
      end
      hcw_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = hcw_pkg::ST_IDLE;
        end
      end
      default: state_next = hcw_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/hsv_color_window_pixel_fraction_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Word
// s_axis    in         tdata {blue, green, red}, tlast = last_pixel
// m_axis    out        tdata {score_fixed, pixel_count, match_count}
// apb       in/out     seven 8-bit or 1-bit settings at 4*index
//
// A pixel passes through accept, prepare, two 8-step divisions through the shared
// restoring divider (start, eight steps, latch for each), then the tally update.
// The last pixel of a frame adds a 20-step score division plus start and emit, and
// emit waits while the previous result still waits on m_axis.
// Reset (rst, synchronous) clears the tallies, the controller and the output valid,
// and restores the red preset. Input stalls while a pixel or a frame's result is in work.
module hsv_color_window_pixel_fraction_core #(
  parameter int MAX_PIXELS = 16777216
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // match_count[24:0], pixel_count[49:25], score_fixed[69:50]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hcw_pkg::cfg_t cfg;
  hcw_pkg::cmd_t cmd;
  hcw_pkg::stat_t stat;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  // Settings registers; writes past the last index drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low_a <= hcw_pkg::RST_HUE_LOW_A;
      cfg.hue_high_a <= hcw_pkg::RST_HUE_HIGH_A;
      cfg.hue_low_b <= hcw_pkg::RST_HUE_LOW_B;
      cfg.hue_high_b <= hcw_pkg::RST_HUE_HIGH_B;
      cfg.window_b_on <= hcw_pkg::RST_WINDOW_B_ON;
      cfg.sat_low <= hcw_pkg::RST_SAT_LOW;
      cfg.val_low <= hcw_pkg::RST_VAL_LOW;
    end else if (wr_en) begin
      case (reg_idx)
        hcw_pkg::REG_HUE_LOW_A: cfg.hue_low_a <= pwdata[7:0];
        hcw_pkg::REG_HUE_HIGH_A: cfg.hue_high_a <= pwdata[7:0];
        hcw_pkg::REG_HUE_LOW_B: cfg.hue_low_b <= pwdata[7:0];
        hcw_pkg::REG_HUE_HIGH_B: cfg.hue_high_b <= pwdata[7:0];
        hcw_pkg::REG_WINDOW_B_ON: cfg.window_b_on <= pwdata[0];
        hcw_pkg::REG_SAT_LOW: cfg.sat_low <= pwdata[7:0];
        hcw_pkg::REG_VAL_LOW: cfg.val_low <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back; unused indexes return zero.
  always_comb begin
    case (reg_idx)
      hcw_pkg::REG_HUE_LOW_A: prdata = {24'b0, cfg.hue_low_a};
      hcw_pkg::REG_HUE_HIGH_A: prdata = {24'b0, cfg.hue_high_a};
      hcw_pkg::REG_HUE_LOW_B: prdata = {24'b0, cfg.hue_low_b};
      hcw_pkg::REG_HUE_HIGH_B: prdata = {24'b0, cfg.hue_high_b};
      hcw_pkg::REG_WINDOW_B_ON: prdata = {31'b0, cfg.window_b_on};
      hcw_pkg::REG_SAT_LOW: prdata = {24'b0, cfg.sat_low};
      hcw_pkg::REG_VAL_LOW: prdata = {24'b0, cfg.val_low};
      default: prdata = '0;
    endcase
  end

  hcw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  hcw_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .stat(stat),
    .pix_data(s_tdata), .pix_last(s_tlast),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule
